### rtl/presence_dimmer_fade_ramp_top_macros.svh
// assertion helpers shared by the checker
`ifndef PRESENCE_DIMMER_FADE_RAMP_TOP_MACROS_SVH
`define PRESENCE_DIMMER_FADE_RAMP_TOP_MACROS_SVH

// same-cycle implication, checked outside reset
`define PDFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define PDFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// next-cycle implication that also covers the reset cycles
`define PDFR_ASSERT_RST(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/pdfr_pkg.sv
package pdfr_pkg;

  localparam int unsigned LEVEL_W   = 8;
  localparam int unsigned FADE_W    = 16;
  localparam int unsigned STEPS_W   = 12;   // 65535 / 20 fits in 12 bits
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [LEVEL_W-1:0] FULL_LEVEL = 8'd255;

  // fade / 20 as (fade * 52429) >> 20, exact over 16-bit fade values
  localparam int unsigned RECIP_W     = 17;
  localparam int unsigned RECIP_SHIFT = 20;
  localparam int unsigned PROD_W      = FADE_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP_TICK = 17'd52429;

  // restoring divider, one quotient bit per cycle
  localparam int unsigned DIV_STEPS = LEVEL_W;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  localparam logic [LEVEL_W-1:0] AWAY_LEVEL_RST = 8'd70;
  localparam logic [FADE_W-1:0]  FADE_RST       = 16'd3000;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_SCAN   = 2'd1,
    CMD_TOGGLE = 2'd2,
    CMD_SET    = 2'd3
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AWAY_LEVEL  = 2'd0,
    REG_FADE_IN     = 2'd1,
    REG_FADE_OUT    = 2'd2,
    REG_SMOOTH_EN   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_RECIP,
    ST_DSTART,
    ST_DWAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic               start;
    logic [LEVEL_W-1:0] dividend;
    logic [STEPS_W-1:0] divisor;
  } div_req_t;

endpackage

### rtl/pdfr_if.sv
interface pdfr_in_if import pdfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         cmd;
  logic               beacon_found;
  logic [LEVEL_W-1:0] target_value;

  modport source (output valid, cmd, beacon_found, target_value, input ready);
  modport sink   (input valid, cmd, beacon_found, target_value, output ready);
  modport mon    (input valid, ready, cmd, beacon_found, target_value);
endinterface

interface pdfr_out_if import pdfr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [LEVEL_W-1:0] level;
  logic [LEVEL_W-1:0] goal;
  logic               away;
  logic               level_changed;

  modport source (output valid, level, goal, away, level_changed, input ready);
  modport sink   (input valid, level, goal, away, level_changed, output ready);
  modport mon    (input valid, ready, level, goal, away, level_changed);
endinterface

interface pdfr_cfg_if import pdfr_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  idx;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, idx, data, input ready);
  modport sink   (input valid, idx, data, output ready);
  modport mon    (input valid, ready, idx, data);
endinterface

### rtl/pdfr_div.sv
module pdfr_div import pdfr_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  div_req_t           req,
  output logic               done,
  output logic [LEVEL_W-1:0] quot
);

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [STEPS_W-1:0]   rem_r, rem_nxt;
  logic [LEVEL_W-1:0]   dq_r, dq_nxt;
  logic [STEPS_W-1:0]   dvs_r, dvs_nxt;
  logic [STEPS_W:0]     shifted;
  logic [STEPS_W:0]     trial;
  logic                 fits;

  assign shifted = {rem_r, dq_r[LEVEL_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};
  assign fits    = shifted >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dq_nxt   = dq_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      rem_nxt  = '0;
      dq_nxt   = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      // remainder stays below the divisor, so it fits the narrower width
      rem_nxt = fits ? trial[STEPS_W-1:0] : shifted[STEPS_W-1:0];
      dq_nxt  = {dq_r[LEVEL_W-2:0], fits};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dq_r  <= dq_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = dq_r;

endmodule

### rtl/presence_dimmer_fade_ramp_top.sv
// presence dimmer with timed fade ramp
// flow: presence, set-target and idle ticks go from acceptance straight to the result register;
//   a tick that steps the level first runs a reciprocal multiply, then a
//   serial divide of the difference by the step count
// throughput: one item at a time; next item taken once the result is registered
// reset (rst_n low, synchronous): level 0, target 0, away set, registers to defaults
module presence_dimmer_fade_ramp_top import pdfr_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  pdfr_in_if.sink     in_ch,
  pdfr_out_if.source  out_ch,
  pdfr_cfg_if.sink    cfg_ch
);

  state_t state_r, state_nxt;

  logic [LEVEL_W-1:0] away_level_r;
  logic [FADE_W-1:0]  fade_in_r, fade_out_r;
  logic               smooth_r;

  logic [LEVEL_W-1:0] cur_r, cur_nxt;
  logic [LEVEL_W-1:0] target_r, target_nxt;
  logic               away_r, away_nxt;
  logic               changed_r, changed_nxt;

  logic               rising_r, rising_nxt;
  logic [LEVEL_W-1:0] mag_r, mag_nxt;
  logic [FADE_W-1:0]  fade_r, fade_nxt;
  logic [STEPS_W-1:0] steps_r, steps_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [LEVEL_W-1:0] out_level_r, out_level_nxt;
  logic [LEVEL_W-1:0] out_goal_r, out_goal_nxt;
  logic               out_away_r, out_away_nxt;
  logic               out_changed_r, out_changed_nxt;

  logic               in_fire;
  logic               rising;
  logic [LEVEL_W-1:0] mag;
  logic [PROD_W-1:0]  prod;
  logic [STEPS_W-1:0] steps_raw;
  logic [LEVEL_W-1:0] step;

  div_req_t           div_req;
  logic               div_done;
  logic [LEVEL_W-1:0] div_quot;

  pdfr_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign in_fire      = in_ch.valid && in_ch.ready;

  assign rising    = target_r > cur_r;
  assign mag       = rising ? (target_r - cur_r) : (cur_r - target_r);
  assign prod      = PROD_W'(fade_r) * PROD_W'(RECIP_TICK);
  assign steps_raw = prod[RECIP_SHIFT +: STEPS_W];
  assign step      = (div_quot == '0) ? LEVEL_W'(1) : div_quot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      away_level_r <= AWAY_LEVEL_RST;
      fade_in_r    <= FADE_RST;
      fade_out_r   <= FADE_RST;
      smooth_r     <= 1'b1;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      case (cfg_idx_t'(cfg_ch.idx))
        REG_AWAY_LEVEL: away_level_r <= cfg_ch.data[LEVEL_W-1:0];
        REG_FADE_IN:    fade_in_r    <= cfg_ch.data[FADE_W-1:0];
        REG_FADE_OUT:   fade_out_r   <= cfg_ch.data[FADE_W-1:0];
        REG_SMOOTH_EN:  smooth_r     <= cfg_ch.data[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    state_nxt       = state_r;
    cur_nxt         = cur_r;
    target_nxt      = target_r;
    away_nxt        = away_r;
    changed_nxt     = changed_r;
    rising_nxt      = rising_r;
    mag_nxt         = mag_r;
    fade_nxt        = fade_r;
    steps_nxt       = steps_r;
    out_valid_nxt   = out_valid_r && !out_ch.ready;
    out_level_nxt   = out_level_r;
    out_goal_nxt    = out_goal_r;
    out_away_nxt    = out_away_r;
    out_changed_nxt = out_changed_r;
    div_req.start    = 1'b0;
    div_req.dividend = mag_r;
    div_req.divisor  = steps_r;

    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          changed_nxt = 1'b0;
          state_nxt   = ST_EMIT;
          case (cmd_t'(in_ch.cmd))
            CMD_TICK: begin
              // differences of 0 or 1 are left alone
              if (smooth_r && (mag > LEVEL_W'(1))) begin
                rising_nxt = rising;
                mag_nxt    = mag;
                fade_nxt   = rising ? fade_in_r : fade_out_r;
                state_nxt  = ST_RECIP;
              end
            end
            CMD_SCAN: begin
              if (in_ch.beacon_found && away_r) begin
                away_nxt   = 1'b0;
                target_nxt = FULL_LEVEL;
              end else if (!in_ch.beacon_found && !away_r) begin
                away_nxt   = 1'b1;
                target_nxt = away_level_r;
              end
            end
            CMD_TOGGLE: begin
              away_nxt   = !away_r;
              target_nxt = away_r ? FULL_LEVEL : away_level_r;
            end
            CMD_SET: begin
              target_nxt = in_ch.target_value;
            end
            default: ;
          endcase
        end
      end
      ST_RECIP: begin
        // a fade shorter than one tick jumps in a single step
        steps_nxt = (steps_raw == '0) ? STEPS_W'(1) : steps_raw;
        state_nxt = ST_DSTART;
      end
      ST_DSTART: begin
        div_req.start = 1'b1;
        state_nxt     = ST_DWAIT;
      end
      ST_DWAIT: begin
        if (div_done) begin
          cur_nxt     = rising_r ? (cur_r + step) : (cur_r - step);
          changed_nxt = 1'b1;
          state_nxt   = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_level_nxt   = cur_r;
          out_goal_nxt    = target_r;
          out_away_nxt    = away_r;
          out_changed_nxt = changed_r;
          state_nxt       = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cur_r       <= '0;
      target_r    <= '0;
      away_r      <= 1'b1;
      changed_r   <= 1'b0;
      rising_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      target_r    <= target_nxt;
      away_r      <= away_nxt;
      changed_r   <= changed_nxt;
      rising_r    <= rising_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r         <= mag_nxt;
    fade_r        <= fade_nxt;
    steps_r       <= steps_nxt;
    out_level_r   <= out_level_nxt;
    out_goal_r    <= out_goal_nxt;
    out_away_r    <= out_away_nxt;
    out_changed_r <= out_changed_nxt;
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.level         = out_level_r;
  assign out_ch.goal          = out_goal_r;
  assign out_ch.away          = out_away_r;
  assign out_ch.level_changed = out_changed_r;

endmodule

### rtl/pdfr_checker.sv
`include "presence_dimmer_fade_ramp_top_macros.svh"

module pdfr_checker import pdfr_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [LEVEL_W-1:0] out_level,
  input logic [LEVEL_W-1:0] out_goal,
  input logic               out_away,
  input logic               out_changed
);

  // a result that is not taken holds until it is
  `PDFR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_level) && $stable(out_goal) && $stable(out_away) && $stable(out_changed), "result changed while stalled")

  // one item at a time: no item is taken in the cycle after an acceptance
  `PDFR_ASSERT_NEXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "input taken while busy")

  // a stepped level reported while present with a full goal never lands above that goal
  `PDFR_ASSERT_NOW(a_no_overshoot, out_valid && out_changed && !out_away && (out_goal == FULL_LEVEL), out_level <= out_goal, "level passed the goal")

  // reset empties the result register
  `PDFR_ASSERT_RST(a_rst_clear, !rst_n, !out_valid, "result valid after reset")

endmodule

bind presence_dimmer_fade_ramp_top pdfr_checker u_pdfr_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_level   (out_ch.level),
  .out_goal    (out_ch.goal),
  .out_away    (out_ch.away),
  .out_changed (out_ch.level_changed)
);
